>>> rtl/slt_pkg.sv
// shared types, constants and token helper functions for the script lexer
package slt_pkg;

    localparam int CNT_W       = 16;
    localparam int KW_CHARS    = 6;
    localparam int KW_BITS     = 8 * KW_CHARS;
    localparam int KW_NUM      = 9;
    localparam int KW_IDX_W    = $clog2(KW_CHARS);
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = Q_PTR_W + 1;
    localparam int SLOTS       = 3;

    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_CONST   = 3'd2;
    localparam logic [2:0] KIND_OPER    = 3'd3;
    localparam logic [2:0] KIND_DELIM   = 3'd4;
    localparam logic [2:0] KIND_PUNCT   = 3'd5;
    localparam logic [2:0] KIND_OTHER   = 3'd6;

    localparam logic [4:0] OP_SLASH   = 5'd0;
    localparam logic [4:0] OP_ASSIGN  = 5'd1;
    localparam logic [4:0] OP_EQ      = 5'd2;
    localparam logic [4:0] OP_NOT     = 5'd3;
    localparam logic [4:0] OP_NE      = 5'd4;
    localparam logic [4:0] OP_LT      = 5'd5;
    localparam logic [4:0] OP_LE      = 5'd6;
    localparam logic [4:0] OP_GT      = 5'd7;
    localparam logic [4:0] OP_GE      = 5'd8;
    localparam logic [4:0] OP_PLUS    = 5'd9;
    localparam logic [4:0] OP_PLUS_EQ = 5'd10;
    localparam logic [4:0] OP_INC     = 5'd11;
    localparam logic [4:0] OP_MINUS   = 5'd12;
    localparam logic [4:0] OP_MINUS_EQ= 5'd13;
    localparam logic [4:0] OP_DEC     = 5'd14;
    localparam logic [4:0] OP_STAR    = 5'd15;
    localparam logic [4:0] OP_STAR_EQ = 5'd16;
    localparam logic [4:0] OP_OR      = 5'd17;
    localparam logic [4:0] OP_LOR     = 5'd18;
    localparam logic [4:0] OP_AND     = 5'd19;
    localparam logic [4:0] OP_LAND    = 5'd20;
    localparam logic [4:0] OP_NONE    = 5'd31;
    localparam logic [4:0] CODE_NONE  = 5'd0;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // keyword bytes packed with the first character lowest
    localparam logic [KW_BITS-1:0] KW_PACKED [KW_NUM] = '{
        KW_BITS'("fi"), KW_BITS'("esle"), KW_BITS'("cnuf"), KW_BITS'("rof"),
        KW_BITS'("elihw"), KW_BITS'("hcae"), KW_BITS'("rav"), KW_BITS'("od"),
        KW_BITS'("nruter")
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3, 3'd2, 3'd6
    };

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_OP,
        MODE_IDENT,
        MODE_CONST,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STAR
    } scan_mode_t;

    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] len;
        logic [7:0]       first;
        logic [4:0]       code;
        logic [2:0]       kind;
    } tok_t;

    typedef struct packed {
        tok_t [SLOTS-1:0]  tok;
        logic [SLOTS-1:0]  valid;
    } bundle_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return c == "=" || c == "!" || c == "<" || c == ">" || c == "+" ||
               c == "-" || c == "*" || c == "|" || c == "&";
    endfunction

    function automatic logic is_tok_mode(input scan_mode_t m);
        return m == MODE_SLASH || m == MODE_OP || m == MODE_IDENT || m == MODE_CONST;
    endfunction

    function automatic logic [4:0] op_single(input logic [7:0] p);
        logic [4:0] code;
        unique case (p)
            "=":     code = OP_ASSIGN;
            "!":     code = OP_NOT;
            "<":     code = OP_LT;
            ">":     code = OP_GT;
            "+":     code = OP_PLUS;
            "-":     code = OP_MINUS;
            "*":     code = OP_STAR;
            "|":     code = OP_OR;
            default: code = OP_AND;
        endcase
        return code;
    endfunction

    function automatic logic [4:0] op_pair(input logic [7:0] p, input logic [7:0] c);
        logic [4:0] code;
        unique case (p)
            "=":     code = (c == "=") ? OP_EQ : OP_NONE;
            "!":     code = (c == "=") ? OP_NE : OP_NONE;
            "<":     code = (c == "=") ? OP_LE : OP_NONE;
            ">":     code = (c == "=") ? OP_GE : OP_NONE;
            "+":     code = (c == "=") ? OP_PLUS_EQ : ((c == "+") ? OP_INC : OP_NONE);
            "-":     code = (c == "=") ? OP_MINUS_EQ : ((c == "-") ? OP_DEC : OP_NONE);
            "*":     code = (c == "=") ? OP_STAR_EQ : OP_NONE;
            "|":     code = (c == "|") ? OP_LOR : OP_NONE;
            "&":     code = (c == "&") ? OP_LAND : OP_NONE;
            default: code = OP_NONE;
        endcase
        return code;
    endfunction

    function automatic tok_t flush_tok(
        input scan_mode_t         m,
        input logic [7:0]         pend,
        input logic [KW_BITS-1:0] kwp,
        input logic [CNT_W-1:0]   run,
        input logic [CNT_W-1:0]   trow,
        input logic [CNT_W-1:0]   tcol
    );
        tok_t t;
        logic hit;
        t       = '0;
        hit     = 1'b0;
        t.row   = trow;
        t.col   = tcol;
        t.first = pend;
        t.len   = run;
        unique case (m)
            MODE_SLASH:
            begin
                t.kind  = KIND_OPER;
                t.code  = OP_SLASH;
                t.first = "/";
                t.len   = CNT_W'(1);
            end
            MODE_OP:
            begin
                t.kind = KIND_OPER;
                t.code = op_single(pend);
                t.len  = CNT_W'(1);
            end
            MODE_IDENT:
            begin
                t.kind = KIND_IDENT;
                for (int k = 0; k < KW_NUM; k++)
                begin
                    if (!hit && run == CNT_W'(KW_LEN[k]) && kwp == KW_PACKED[k])
                    begin
                        hit    = 1'b1;
                        t.kind = KIND_KEYWORD;
                        t.code = 5'(k);
                    end
                end
            end
            MODE_CONST:
            begin
                t.kind = KIND_CONST;
            end
            default:
            begin
                t.kind = KIND_OTHER;
            end
        endcase
        return t;
    endfunction

endpackage

>>> rtl/script_lexer_tokenizer_core.sv
// top level of the streaming script lexer
// path: result items of a byte pass through the bundle queue, then the output register
// throughput: one byte per cycle unless the queue is full, one result item per cycle
//   while m_tready is high; a byte's two or three items wait in the 4-entry queue
// reset: rst_n clears position counters to row 1, column 0, empties queue and output
module script_lexer_tokenizer_core
    import slt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // token_kind, token_code, first_char, lexeme_length,
                                   // start_row, start_column
    output logic        m_tlast    // last_of_run
);

    logic    push, q_full, pop, head_valid;
    bundle_t push_data, head;
    tok_t    out_tok;

    slt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .bundle   (push_data)
    );

    slt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    slt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_tok    (out_tok),
        .out_last   (m_tlast)
    );

    assign m_tdata = out_tok;

endmodule

>>> rtl/slt_front.sv
// front end: classifies each byte, tracks lexer state and builds result bundles
module slt_front
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       q_full,
    output logic       push,
    output bundle_t    bundle
);

    scan_mode_t         mode_reg, mode_next, cmode, start_mode, mid_mode;
    logic [7:0]         pend_reg, pend_next, mid_pend;
    logic [KW_BITS-1:0] kwp_reg, kwp_next, mid_kwp;
    logic [CNT_W-1:0]   run_reg, run_next, mid_run;
    logic [CNT_W-1:0]   row_reg, row_next, mid_row;
    logic [CNT_W-1:0]   col_reg, col_next, mid_col;
    logic [CNT_W-1:0]   trow_reg, trow_next, mid_trow;
    logic [CNT_W-1:0]   tcol_reg, tcol_next, mid_tcol;

    logic       fire, is_cr, is_nl, is_sep;
    logic       restart, pair_hit, do_extend;
    logic       start_emit;
    logic [2:0] start_kind;
    logic [4:0] pair_code;
    tok_t       flush_cur, flush_mid, pair_tok, start_tok, end_tok;

    assign in_ready  = !q_full;
    assign fire      = in_valid && in_ready;
    assign is_cr     = in_char == CH_CR;
    assign is_nl     = in_char == CH_NL;
    assign is_sep    = in_char == CH_SPACE || is_nl;
    assign pair_code = op_pair(pend_reg, in_char);

    // what a new token started by this byte looks like
    always_comb
    begin
        start_mode = MODE_IDLE;
        start_emit = 1'b0;
        start_kind = KIND_OTHER;
        priority if (is_sep)
        begin
            start_mode = MODE_IDLE;
        end
        else if (in_char == "/")
        begin
            start_mode = MODE_SLASH;
        end
        else if (in_char == "{" || in_char == "}" || in_char == "(" ||
                 in_char == ")" || in_char == "[" || in_char == "]")
        begin
            start_emit = 1'b1;
            start_kind = KIND_DELIM;
        end
        else if (in_char == ":" || in_char == ";" || in_char == ",")
        begin
            start_emit = 1'b1;
            start_kind = KIND_PUNCT;
        end
        else if (is_op_start(in_char))
        begin
            start_mode = MODE_OP;
        end
        else if (is_letter(in_char))
        begin
            start_mode = MODE_IDENT;
        end
        else if (is_digit(in_char) || in_char == ".")
        begin
            start_mode = MODE_CONST;
        end
        else
        begin
            start_emit = 1'b1;
            start_kind = KIND_OTHER;
        end
    end

    // per-mode decision for the incoming byte
    always_comb
    begin
        restart   = 1'b0;
        pair_hit  = 1'b0;
        do_extend = 1'b0;
        cmode     = mode_reg;
        if (!is_cr)
        begin
            unique case (mode_reg)
                MODE_LINE:
                begin
                    if (is_nl)
                        cmode = MODE_IDLE;
                end
                MODE_BLOCK:
                begin
                    if (in_char == "*")
                        cmode = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (in_char == "/")
                        cmode = MODE_IDLE;
                    else if (in_char != "*")
                        cmode = MODE_BLOCK;
                end
                MODE_SLASH:
                begin
                    if (in_char == "/")
                        cmode = MODE_LINE;
                    else if (in_char == "*")
                        cmode = MODE_BLOCK;
                    else
                        restart = 1'b1;
                end
                MODE_OP:
                begin
                    if (pair_code != OP_NONE)
                        pair_hit = 1'b1;
                    else
                        restart = 1'b1;
                end
                MODE_IDENT:
                begin
                    if (is_letter(in_char) || is_digit(in_char))
                        do_extend = 1'b1;
                    else
                        restart = 1'b1;
                end
                MODE_CONST:
                begin
                    if (is_digit(in_char) || in_char == ".")
                        do_extend = 1'b1;
                    else
                        restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase
        end
    end

    // state after this byte, then next state
    always_comb
    begin
        mid_mode = cmode;
        mid_pend = pend_reg;
        mid_kwp  = kwp_reg;
        mid_run  = run_reg;
        mid_row  = row_reg;
        mid_col  = col_reg;
        mid_trow = trow_reg;
        mid_tcol = tcol_reg;
        if (!is_cr)
        begin
            if (is_nl)
            begin
                mid_row = sat_inc(row_reg);
                mid_col = '0;
            end
            else
            begin
                mid_col = sat_inc(col_reg);
            end
        end
        if (pair_hit)
            mid_mode = MODE_IDLE;
        if (restart)
        begin
            mid_mode = start_mode;
            mid_trow = mid_row;
            mid_tcol = mid_col;
            if (!is_sep)
            begin
                mid_pend = in_char;
                mid_run  = CNT_W'(1);
                mid_kwp  = KW_BITS'(in_char);
            end
        end
        if (do_extend)
        begin
            for (int i = 0; i < KW_CHARS; i++)
            begin
                if (run_reg == CNT_W'(i))
                    mid_kwp[i*8 +: 8] = in_char;
            end
            mid_run = sat_inc(run_reg);
        end

        if (!fire)
        begin
            mode_next = mode_reg;
            pend_next = pend_reg;
            kwp_next  = kwp_reg;
            run_next  = run_reg;
            row_next  = row_reg;
            col_next  = col_reg;
            trow_next = trow_reg;
            tcol_next = tcol_reg;
        end
        else if (in_last)
        begin
            mode_next = MODE_IDLE;
            pend_next = '0;
            kwp_next  = '0;
            run_next  = '0;
            row_next  = CNT_W'(1);
            col_next  = '0;
            trow_next = CNT_W'(1);
            tcol_next = '0;
        end
        else
        begin
            mode_next = mid_mode;
            pend_next = mid_pend;
            kwp_next  = mid_kwp;
            run_next  = mid_run;
            row_next  = mid_row;
            col_next  = mid_col;
            trow_next = mid_trow;
            tcol_next = mid_tcol;
        end
    end

    // result bundle: flushed or paired token, started or final token, end marker
    always_comb
    begin
        flush_cur = flush_tok(mode_reg, pend_reg, kwp_reg, run_reg, trow_reg, tcol_reg);
        flush_mid = flush_tok(mid_mode, mid_pend, mid_kwp, mid_run, mid_trow, mid_tcol);

        pair_tok       = '0;
        pair_tok.kind  = KIND_OPER;
        pair_tok.code  = pair_code;
        pair_tok.first = pend_reg;
        pair_tok.len   = CNT_W'(2);
        pair_tok.row   = trow_reg;
        pair_tok.col   = tcol_reg;

        start_tok       = '0;
        start_tok.kind  = start_kind;
        start_tok.code  = CODE_NONE;
        start_tok.first = in_char;
        start_tok.len   = CNT_W'(1);
        start_tok.row   = mid_row;
        start_tok.col   = mid_col;

        end_tok      = '0;
        end_tok.kind = KIND_OTHER;
        end_tok.row  = mid_row;
        end_tok.col  = mid_col;

        bundle          = '0;
        bundle.valid[0] = pair_hit || (restart && is_tok_mode(mode_reg));
        bundle.tok[0]   = pair_hit ? pair_tok : flush_cur;
        if (restart && start_emit)
        begin
            bundle.valid[1] = 1'b1;
            bundle.tok[1]   = start_tok;
        end
        else if (in_last && is_tok_mode(mid_mode))
        begin
            bundle.valid[1] = 1'b1;
            bundle.tok[1]   = flush_mid;
        end
        bundle.valid[2] = in_last;
        bundle.tok[2]   = end_tok;
    end

    assign push = fire && (|bundle.valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pend_reg <= '0;
            kwp_reg  <= '0;
            run_reg  <= '0;
            row_reg  <= CNT_W'(1);
            col_reg  <= '0;
            trow_reg <= CNT_W'(1);
            tcol_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            kwp_reg  <= kwp_next;
            run_reg  <= run_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            trow_reg <= trow_next;
            tcol_reg <= tcol_next;
        end
    end

endmodule

>>> rtl/slt_queue.sv
// short bundle queue between front and back end
module slt_queue
    import slt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head
);

    // depth is a power of two so the pointers wrap on their own
    bundle_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full       = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/slt_back.sv
// back end: unpacks bundles into single result items behind an output register
module slt_back
    import slt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  bundle_t head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output tok_t    out_tok,
    output logic    out_last
);

    logic [SLOTS-1:0] done_reg, done_next;
    logic [SLOTS-1:0] pending, pick, rest;
    logic             valid_reg, valid_next;
    tok_t             tok_reg, tok_next;
    logic             last_reg, last_next;
    logic             load;
    tok_t             pick_tok;

    assign pending = head.valid & ~done_reg;
    assign load    = head_valid && (!valid_reg || out_ready);

    // lowest outstanding slot goes first
    always_comb
    begin
        pick     = '0;
        pick_tok = head.tok[0];
        priority if (pending[0])
        begin
            pick     = SLOTS'(1);
            pick_tok = head.tok[0];
        end
        else if (pending[1])
        begin
            pick     = SLOTS'(2);
            pick_tok = head.tok[1];
        end
        else
        begin
            pick     = SLOTS'(4);
            pick_tok = head.tok[2];
        end
    end

    assign rest = pending & ~pick;
    assign pop  = load && (rest == '0);

    always_comb
    begin
        done_next  = done_reg;
        valid_next = valid_reg;
        tok_next   = tok_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            tok_next   = pick_tok;
            last_next  = rest == '0;
            done_next  = (rest == '0) ? '0 : (done_reg | pick);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> dv/tb.sv
// self-checking testbench for the streaming script lexer core
`timescale 1ns / 100ps

module tb;
    import slt_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 70;
    localparam int PRINT_CAP    = 50;

    class token_scoreboard;
        string            kw_text [KW_NUM] = '{"if", "else", "func", "for", "while",
                                               "each", "var", "do", "return"};
        string            op_text [int'(OP_LAND) + 1] = '{"/", "=", "==", "!", "!=", "<",
                                                          "<=", ">", ">=", "+", "+=", "++",
                                                          "-", "-=", "--", "*", "*=", "|",
                                                          "||", "&", "&&"};
        scan_mode_t       mode;
        logic [7:0]       pend;
        logic [7:0]       kw_buf [KW_CHARS];
        logic [CNT_W-1:0] run_len;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] tok_row;
        logic [CNT_W-1:0] tok_col;
        tok_t             step_toks [$];
        tok_t             tok_q [$];
        bit               tok_last_q [$];
        int               mismatches;
        int               checked;
        int               bytes_seen;

        function new();
            clear_state();
            mismatches = 0;
            checked    = 0;
            bytes_seen = 0;
        endfunction

        function void clear_state();
            mode    = MODE_IDLE;
            pend    = 8'h00;
            foreach (kw_buf[i])
                kw_buf[i] = 8'h00;
            run_len = '0;
            row     = CNT_W'(1);
            col     = '0;
            tok_row = CNT_W'(1);
            tok_col = '0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit numeral(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void push_tok(logic [2:0] kind, logic [4:0] code, logic [7:0] first,
                               logic [CNT_W-1:0] len);
            tok_t t;
            if (step_toks.size() >= SLOTS)
                return;
            t.kind  = kind;
            t.code  = code;
            t.first = first;
            t.len   = len;
            t.row   = tok_row;
            t.col   = tok_col;
            step_toks.push_back(t);
        endfunction

        function int keyword_index();
            int  k;
            int  i;
            bit  same;
            for (k = 0; k < KW_NUM; k++)
            begin
                if (run_len == CNT_W'(kw_text[k].len()))
                begin
                    same = 1'b1;
                    for (i = 0; i < kw_text[k].len(); i++)
                        if (kw_buf[i] != kw_text[k][i])
                            same = 1'b0;
                    if (same)
                        return k;
                end
            end
            return -1;
        endfunction

        // n is the operator length: one byte p, or the pair p,c
        function int op_index(logic [7:0] p, logic [7:0] c, int n);
            int k;
            for (k = 0; k <= int'(OP_LAND); k++)
                if (op_text[k].len() == n && op_text[k][0] == p &&
                    (n == 1 || op_text[k][1] == c))
                    return k;
            return -1;
        endfunction

        function void flush_pending();
            int kw;
            kw = keyword_index();
            case (mode)
                MODE_SLASH: push_tok(KIND_OPER, OP_SLASH, "/", CNT_W'(1));
                MODE_OP:    push_tok(KIND_OPER, 5'(op_index(pend, 8'h00, 1)), pend, CNT_W'(1));
                MODE_IDENT:
                begin
                    if (kw >= 0)
                        push_tok(KIND_KEYWORD, 5'(kw), pend, run_len);
                    else
                        push_tok(KIND_IDENT, CODE_NONE, pend, run_len);
                end
                MODE_CONST: push_tok(KIND_CONST, CODE_NONE, pend, run_len);
                default:    ;
            endcase
            mode = MODE_IDLE;
        endfunction

        function void begin_token(logic [7:0] c);
            tok_row = row;
            tok_col = col;
            mode    = MODE_IDLE;
            if (c == CH_SPACE || c == CH_NL)
                return;
            pend    = c;
            run_len = CNT_W'(1);
            foreach (kw_buf[i])
                kw_buf[i] = 8'h00;
            kw_buf[0] = c;
            case (c)
                "/":                          mode = MODE_SLASH;
                "{", "}", "(", ")", "[", "]": push_tok(KIND_DELIM, CODE_NONE, c, CNT_W'(1));
                ":", ";", ",":                push_tok(KIND_PUNCT, CODE_NONE, c, CNT_W'(1));
                "=", "!", "<", ">", "+", "-", "*", "|", "&":
                                              mode = MODE_OP;
                default:
                begin
                    if (alpha(c))
                        mode = MODE_IDENT;
                    else if (numeral(c) || c == ".")
                        mode = MODE_CONST;
                    else
                        push_tok(KIND_OTHER, CODE_NONE, c, CNT_W'(1));
                end
            endcase
        endfunction

        function void extend(logic [7:0] c);
            if (run_len < KW_CHARS)
                kw_buf[run_len] = c;
            run_len = bump(run_len);
        endfunction

        function void consume(logic [7:0] c);
            int code;
            if (c == CH_NL)
            begin
                row = bump(row);
                col = '0;
            end
            else
                col = bump(col);
            case (mode)
                MODE_LINE:
                begin
                    if (c == CH_NL)
                        mode = MODE_IDLE;
                    return;
                end
                MODE_BLOCK:
                begin
                    if (c == "*")
                        mode = MODE_STAR;
                    return;
                end
                MODE_STAR:
                begin
                    if (c == "/")
                        mode = MODE_IDLE;
                    else if (c != "*")
                        mode = MODE_BLOCK;
                    return;
                end
                MODE_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode = MODE_LINE;
                        return;
                    end
                    if (c == "*")
                    begin
                        mode = MODE_BLOCK;
                        return;
                    end
                end
                MODE_OP:
                begin
                    code = op_index(pend, c, 2);
                    if (code >= 0)
                    begin
                        push_tok(KIND_OPER, 5'(code), pend, CNT_W'(2));
                        mode = MODE_IDLE;
                        return;
                    end
                end
                MODE_IDENT:
                begin
                    if (alpha(c) || numeral(c))
                    begin
                        extend(c);
                        return;
                    end
                end
                MODE_CONST:
                begin
                    if (numeral(c) || c == ".")
                    begin
                        extend(c);
                        return;
                    end
                end
                default: ;
            endcase
            flush_pending();
            begin_token(c);
        endfunction

        function void note_byte(logic [7:0] c, bit last);
            step_toks.delete();
            bytes_seen++;
            if (c != CH_CR)
                consume(c);
            if (last)
            begin
                flush_pending();
                tok_row = row;
                tok_col = col;
                push_tok(KIND_OTHER, CODE_NONE, 8'h00, '0);
                clear_state();
            end
            foreach (step_toks[i])
            begin
                tok_q.push_back(step_toks[i]);
                tok_last_q.push_back(i == step_toks.size() - 1);
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("error: %s", msg);
        endtask

        task check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (want !== got)
                report($sformatf("token %0d %s: expected %0d, got %0d", checked, name, want, got));
        endtask

        task check_token(tok_t got, logic got_last);
            tok_t want;
            bit   want_last;
            checked++;
            if (tok_q.size() == 0)
            begin
                report($sformatf("token %0d arrived with none pending, data %h", checked, got));
                return;
            end
            want      = tok_q.pop_front();
            want_last = tok_last_q.pop_front();
            check_field("kind", CNT_W'(want.kind), CNT_W'(got.kind));
            check_field("code", CNT_W'(want.code), CNT_W'(got.code));
            check_field("first_char", CNT_W'(want.first), CNT_W'(got.first));
            check_field("length", want.len, got.len);
            check_field("start_row", want.row, got.row);
            check_field("start_column", want.col, got.col);
            check_field("last_of_run", CNT_W'(want_last), CNT_W'(got_last));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // in_char
    logic        s_tlast  = 1'b0;    // end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // kind, code, first_char, length, start_row, start_column
    logic        m_tlast;            // last_of_run

    token_scoreboard sb;
    logic [7:0]      stim_bytes [$];
    bit              stim_last [$];
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              hold_ask       = 0;
    int              hold_grant     = 0;
    int              hold_left      = 0;
    int              quiet_cycles   = 0;
    string           letters        = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string           alnum          = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string           const_chars    = "0123456789.";
    string           delims         = "{}()[]";
    string           puncts         = ":;,";
    string           block_chars    = "ab */\n*";

    script_lexer_tokenizer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_grant != hold_ask)
            begin
                hold_grant = hold_ask;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_token(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    task automatic add_byte(logic [7:0] b);
        stim_bytes.push_back(b);
        stim_last.push_back(1'b0);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic end_stream();
        stim_last[stim_last.size() - 1] = 1'b1;
    endtask

    task automatic add_fragment();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 15)
            add_text(sb.kw_text[$urandom_range(KW_NUM - 1)]);
        else if (pick < 30)
        begin
            if ($urandom_range(3) == 0)
                add_text(sb.kw_text[$urandom_range(KW_NUM - 1)]);
            else
                add_byte(letters[$urandom_range(letters.len() - 1)]);
            n = $urandom_range(8);
            for (int i = 0; i < n; i++)
                add_byte(alnum[$urandom_range(alnum.len() - 1)]);
        end
        else if (pick < 42)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_byte(const_chars[$urandom_range(const_chars.len() - 1)]);
        end
        else if (pick < 60)
            add_text(sb.op_text[$urandom_range(int'(OP_LAND))]);
        else if (pick < 68)
            add_byte(delims[$urandom_range(delims.len() - 1)]);
        else if (pick < 74)
            add_byte(puncts[$urandom_range(puncts.len() - 1)]);
        else if (pick < 79)
        begin
            add_text("//");
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
            begin
                b = 8'($urandom_range(255));
                add_byte(b == CH_NL ? CH_SPACE : b);
            end
            add_byte(CH_NL);
        end
        else if (pick < 84)
        begin
            add_text("/*");
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
                add_byte(block_chars[$urandom_range(block_chars.len() - 1)]);
            // sometimes the stream ends inside the comment
            if ($urandom_range(9) == 0)
            begin
                end_stream();
                return;
            end
            add_text("*/");
        end
        else if (pick < 92)
            add_byte(8'($urandom_range(255)));
        else
        begin
            case ($urandom_range(4))
                0:       add_text(" ");
                1:       add_byte(CH_NL);
                2:       add_text("\r\n");
                3:       add_byte(CH_CR);
                default: add_text("\t");
            endcase
        end
        case ($urandom_range(9))
            6, 7:    ;
            8:       add_byte(CH_NL);
            9:       add_text("\r\n");
            default: add_byte(CH_SPACE);
        endcase
        if ($urandom_range(29) == 0)
            end_stream();
    endtask

    task automatic send_byte(logic [7:0] c, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_queued();
        foreach (stim_bytes[i])
            send_byte(stim_bytes[i], stim_last[i]);
        stim_bytes.delete();
        stim_last.delete();
    endtask

    task automatic run_phase(int sender_pct, int recv_pct, int n_items);
        send_idle_pct = sender_pct;
        recv_stall_pct <= recv_pct;
        while (stim_bytes.size() < n_items)
            add_fragment();
        send_queued();
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_text("if x==1{y+=2;}\r\n");
        add_text("/*a**/b//c\n");
        add_text("<=>!&|-*/.5");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("\treturn7 ");
        add_text("ab\r");
        end_stream();
        add_text("k(");
        end_stream();
        add_text("x/*open");
        end_stream();
        run_phase(0, 0, 0);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(65, 0, PHASE_ITEMS);
        run_phase(0, 65, PHASE_ITEMS);
        run_phase(22, 22, PHASE_ITEMS);

        // output held off while bytes keep coming, so the input must stall
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_ask <= hold_ask + 1;
        repeat (8)
            add_text("f(x);");
        end_stream();
        send_queued();
        s_tvalid <= 1'b0;

        while (sb.tok_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.tok_q.size() != 0)
            sb.report($sformatf("%0d tokens never arrived", sb.tok_q.size()));

        $display("run covered %0d source bytes and %0d tokens: directed cases, idle and stall mixes,",
                 sb.bytes_seen, sb.checked);
        $display("comments, operators, stray bytes and a long output hold-off that fills the block");
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> script_lexer_tokenizer_core.f
rtl/slt_pkg.sv
rtl/slt_front.sv
rtl/slt_queue.sv
rtl/slt_back.sv
rtl/script_lexer_tokenizer_core.sv
dv/tb.sv
